### rtl/rae_pkg.sv
// Shared constants and types for the radiance accumulator with RGBE readout.
`default_nettype none
package rae_pkg;

  localparam int MAX_DIM  = 256;
  localparam int NPIX     = MAX_DIM * MAX_DIM;
  localparam int PIX_W    = $clog2(NPIX);
  localparam int DIM_W    = 9;
  localparam int POS_W    = 16;
  localparam int TOT_W    = 17;
  localparam int ACC_W    = 48;
  localparam int SMP_W    = 32;
  localparam int QUO_W    = ACC_W - 1;
  localparam int DIV_W    = 24;
  localparam int P_W      = $clog2(QUO_W);
  localparam int MAN_W    = 8;
  localparam int EXP_BIAS = 113;
  localparam int NCH      = 3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ITER   = 2'd2;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef logic [QUO_W-1:0] rae_quo_t;
  typedef logic [MAN_W-1:0] rae_man_t;

  typedef struct packed {
    logic             clr;
    logic             acc_wr;
    logic             div_load;
    logic             div_step;
    logic [PIX_W-1:0] addr;
  } rae_lane_ctl_t;

endpackage
`default_nettype wire

### rtl/rae_if.sv
// Valid/ready channel interfaces for sample words and RGBE result words.
`default_nettype none
interface rae_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic signed [31:0] radiance_red;
  logic signed [31:0] radiance_green;
  logic signed [31:0] radiance_blue;

  modport source (output valid, func, x_pos, y_pos, radiance_red, radiance_green,
                  radiance_blue, input ready);
  modport sink (input valid, func, x_pos, y_pos, radiance_red, radiance_green,
                radiance_blue, output ready);
endinterface

interface rae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_mantissa;
  logic [7:0] green_mantissa;
  logic [7:0] blue_mantissa;
  logic [7:0] shared_exponent;
  logic       last_pixel;

  modport source (output valid, red_mantissa, green_mantissa, blue_mantissa,
                  shared_exponent, last_pixel, input ready);
  modport sink (input valid, red_mantissa, green_mantissa, blue_mantissa,
                shared_exponent, last_pixel, output ready);
endinterface
`default_nettype wire

### rtl/rae_lane.sv
// One color channel: accumulator memory, saturating add and bit-serial divider.
`default_nettype none
module rae_lane
  import rae_pkg::*;
(
  input  wire logic                    clk,
  input  wire rae_lane_ctl_t           ctl,
  input  wire logic signed [SMP_W-1:0] sample,
  input  wire logic [DIV_W-1:0]        divisor,
  output logic                         q_bit,
  output rae_quo_t                     quot
);

  logic signed [ACC_W-1:0] mem [NPIX];
  logic signed [ACC_W-1:0] rd_data_r;
  logic signed [ACC_W:0]   sum;
  logic signed [ACC_W-1:0] sat_sum;
  logic signed [ACC_W-1:0] wr_data;
  logic [DIV_W:0]          rem_r, rem_nxt, trial;
  rae_quo_t                dvd_r, dvd_nxt, quot_r, quot_nxt;

  always_comb begin
    sum = {rd_data_r[ACC_W-1], rd_data_r} + {{(ACC_W+1-SMP_W){sample[SMP_W-1]}}, sample};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      sat_sum = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_sum = sum[ACC_W-1:0];
    end
    wr_data = ctl.clr ? '0 : sat_sum;
  end

  always_ff @(posedge clk) begin
    if (ctl.clr || ctl.acc_wr) begin
      mem[ctl.addr] <= wr_data;
    end
    rd_data_r <= mem[ctl.addr];
  end

  // Restoring division, one quotient bit per step, most significant first.
  always_comb begin
    trial    = {rem_r[DIV_W-1:0], dvd_r[QUO_W-1]};
    q_bit    = (trial >= {1'b0, divisor});
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    if (ctl.div_load) begin
      rem_nxt = '0;
      dvd_nxt = rd_data_r[ACC_W-1] ? '0 : rd_data_r[QUO_W-1:0];
    end else if (ctl.div_step) begin
      rem_nxt  = q_bit ? (trial - {1'b0, divisor}) : trial;
      dvd_nxt  = {dvd_r[QUO_W-2:0], 1'b0};
      quot_nxt = {quot_r[QUO_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = quot_r;

endmodule
`default_nettype wire

### rtl/rae_merge.sv
// Combines the three channel quotients into RGBE mantissas and shared exponent.
`default_nettype none
module rae_merge
  import rae_pkg::*;
(
  input  wire rae_quo_t         quot [NCH],
  input  wire logic             found,
  input  wire logic [P_W-1:0]   top_bit,
  output rae_man_t              mant [NCH],
  output logic [MAN_W-1:0]      exponent
);

  logic [QUO_W+MAN_W-2:0] ext [NCH];

  // The top set bit of the largest channel lands on mantissa bit 7.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ext[c]  = {quot[c], {(MAN_W-1){1'b0}}} >> top_bit;
      mant[c] = found ? ext[c][MAN_W-1:0] : '0;
    end
    exponent = '0;
    if (found) begin
      exponent = MAN_W'({2'b0, top_bit} + MAN_W'(EXP_BIAS));
    end
  end

endmodule
`default_nettype wire

### rtl/radiance_accumulate_rgbe_out.sv
// Top level: sequencer, address generation, three channel lanes and output register.
//
//  Channel  Dir  Handshake         Word
//  in_ch    in   valid/ready       func, x_pos, y_pos, radiance_red/green/blue
//  out_ch   out  valid/ready       red/green/blue_mantissa, shared_exponent, last_pixel
//  cfg_*    in   write enable only image_width, image_height, iteration_count
//
// After reset a clearing pass zeroes the accumulator memories, one pixel per
// cycle, during which in_ch.ready stays low (configuration writes are still
// taken). An add word goes through accept, memory read and write back; an add
// word outside the image is dropped at accept. A readout word goes through accept,
// read, divider load, 47 steps of the bit-serial divider in each lane, then encode
// into the output register. One word is worked on at a time; the encoded result
// waits in the output register while the next input word is accepted, and encode
// stalls only if the previous result has not been taken.
`default_nettype none
module radiance_accumulate_rgbe_out
  import rae_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  rae_in_if.sink           in_ch,
  rae_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [23:0] cfg_wdata
);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_ENC} state_t;

  state_t                 state_r;
  logic [DIM_W-1:0]       width_r, height_r;
  logic [DIV_W-1:0]       iter_r;
  logic [PIX_W-1:0]       clr_cnt_r;
  logic [POS_W-1:0]       pos_r;
  logic [PIX_W-1:0]       addr_r;
  logic                   func_r;
  logic                   last_r;
  logic signed [SMP_W-1:0] smp_r [NCH];
  logic [P_W-1:0]         step_r;
  logic [P_W-1:0]         top_r;
  logic                   found_r;
  logic                   out_valid_r;
  rae_man_t               out_mant_r [NCH];
  logic [MAN_W-1:0]       out_exp_r;
  logic                   out_last_r;

  logic [DIM_W-1:0]       dim_wr;
  logic [TOT_W-1:0]       total;
  logic                   x_ok, y_ok;
  logic [DIM_W-1:0]       row;
  logic [2*DIM_W-1:0]     idx;
  logic [POS_W-1:0]       pos_eff;
  logic [TOT_W-1:0]       pos_inc;
  logic [DIV_W-1:0]       divisor;
  rae_lane_ctl_t          ctl;
  logic [NCH-1:0]         q_bits;
  rae_quo_t               quot [NCH];
  rae_man_t               mant [NCH];
  logic [MAN_W-1:0]       exponent;
  logic                   accept;
  logic                   out_free;

  // Register writes clamp the dimensions to 1..MAX_DIM.
  always_comb begin
    dim_wr = cfg_wdata[DIM_W-1:0];
    if (dim_wr == '0) begin
      dim_wr = DIM_W'(1);
    end else if (dim_wr > DIM_W'(MAX_DIM)) begin
      dim_wr = DIM_W'(MAX_DIM);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      iter_r   <= DIV_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= dim_wr;
        REG_HEIGHT: height_r <= dim_wr;
        REG_ITER:   iter_r   <= cfg_wdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  assign divisor  = (iter_r == '0) ? DIV_W'(1) : iter_r;
  assign total    = TOT_W'(width_r) * TOT_W'(height_r);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Sample address: rows are stored flipped in y.
  always_comb begin
    x_ok    = !in_ch.x_pos[15] && (in_ch.x_pos[14:0] < 15'(width_r));
    y_ok    = !in_ch.y_pos[15] && (in_ch.y_pos[14:0] < 15'(height_r));
    row     = height_r - DIM_W'(1) - in_ch.y_pos[DIM_W-1:0];
    idx     = (2*DIM_W)'(in_ch.x_pos[DIM_W-1:0]) + row * width_r;
    pos_eff = ({1'b0, pos_r} >= total) ? '0 : pos_r;
    pos_inc = TOT_W'(pos_eff) + TOT_W'(1);
  end

  always_comb begin
    ctl          = '0;
    ctl.addr     = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
    ctl.clr      = (state_r == ST_CLEAR);
    ctl.acc_wr   = (state_r == ST_EXEC) && (func_r == FUNC_ADD);
    ctl.div_load = (state_r == ST_EXEC) && (func_r == FUNC_READ);
    ctl.div_step = (state_r == ST_DIV);
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      // In the encode state the output register is handled below.
      if (out_valid_r && out_ch.ready && (state_r != ST_ENC)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + PIX_W'(1);
          if (clr_cnt_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            func_r <= in_ch.func;
            smp_r[0] <= in_ch.radiance_red;
            smp_r[1] <= in_ch.radiance_green;
            smp_r[2] <= in_ch.radiance_blue;
            if (in_ch.func == FUNC_READ) begin
              addr_r  <= pos_eff;
              last_r  <= (TOT_W'(pos_eff) == total - TOT_W'(1));
              pos_r   <= (pos_inc >= total) ? '0 : pos_inc[POS_W-1:0];
              state_r <= ST_READ;
            end else if (x_ok && y_ok) begin
              addr_r  <= idx[PIX_W-1:0];
              state_r <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          step_r  <= P_W'(QUO_W - 1);
          found_r <= 1'b0;
          state_r <= (func_r == FUNC_READ) ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          // The first quotient bit set in any lane marks the top bit of the maximum.
          if (!found_r && (q_bits != '0)) begin
            found_r <= 1'b1;
            top_r   <= step_r;
          end
          step_r <= step_r - P_W'(1);
          if (step_r == '0) begin
            state_r <= ST_ENC;
          end
        end
        ST_ENC: begin
          if (out_free) begin
            out_mant_r  <= mant;
            out_exp_r   <= exponent;
            out_last_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    rae_lane u_lane (
      .clk     (clk),
      .ctl     (ctl),
      .sample  (smp_r[c]),
      .divisor (divisor),
      .q_bit   (q_bits[c]),
      .quot    (quot[c])
    );
  end

  rae_merge u_merge (
    .quot     (quot),
    .found    (found_r),
    .top_bit  (top_r),
    .mant     (mant),
    .exponent (exponent)
  );

  assign out_ch.valid           = out_valid_r;
  assign out_ch.red_mantissa    = out_mant_r[0];
  assign out_ch.green_mantissa  = out_mant_r[1];
  assign out_ch.blue_mantissa   = out_mant_r[2];
  assign out_ch.shared_exponent = out_exp_r;
  assign out_ch.last_pixel      = out_last_r;

endmodule
`default_nettype wire

### rtl/rae_checker.sv
// Port-level checks for the radiance accumulator, bound to the top level.
`default_nettype none
module rae_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_func,
  input wire logic out_valid,
  input wire logic out_ready
);

  // The clearing pass blocks input right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    !$past(rst_n) && rst_n |-> !in_ready) else $error("input ready during clear");

  // One word at a time: an accepted readout word closes the input for the next cycle.
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func |=> !in_ready) else $error("second word accepted early");

  // An add word never produces a result.
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func && !out_valid |=> !out_valid)
    else $error("result after add word");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

bind radiance_accumulate_rgbe_out rae_checker u_rae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
`default_nettype wire
